>>> hdl/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// Operation and error codes, and the command and status words that pass
// between the queue controller and the queue datapath.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_REMOVE = 1'b1;

  localparam logic [1:0] ERR_OK    = 2'd0;
  localparam logic [1:0] ERR_FULL  = 2'd1;
  localparam logic [1:0] ERR_EMPTY = 2'd2;

  typedef struct packed {
    logic       load;    // capture a result word
    logic       insert;  // place the request entry
    logic       remove;  // drop the head entry
    logic [1:0] err;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } stat_t;

endpackage

>>> hdl/spq_req_if.sv
// ----------------------------------------------------------------------------
// spq_req_if
// Request channel: operation, data word and priority, with valid/ready.
// ----------------------------------------------------------------------------
interface spq_req_if #(
  parameter int DW = 32,
  parameter int PW = 16
);
  logic          valid;
  logic          ready;
  logic          func;
  logic [DW-1:0] item_value;
  logic [PW-1:0] item_priority;

  modport source (output valid, func, item_value, item_priority, input ready);
  modport sink   (input valid, func, item_value, item_priority, output ready);
  modport mon    (input valid, ready, func, item_value, item_priority);
endinterface

>>> hdl/spq_res_if.sv
// ----------------------------------------------------------------------------
// spq_res_if
// Result channel: removed entry, head entry, fill state and error code.
// ----------------------------------------------------------------------------
interface spq_res_if #(
  parameter int DW = 32,
  parameter int CW = 5
);
  logic          valid;
  logic          ready;
  logic [DW-1:0] removed_value;
  logic          removed_valid;
  logic [DW-1:0] head_value;
  logic          is_empty_flag;
  logic [CW-1:0] entry_count;
  logic [1:0]    error_code;

  modport source (output valid, removed_value, removed_valid, head_value,
                  is_empty_flag, entry_count, error_code, input ready);
  modport sink   (input valid, removed_value, removed_valid, head_value,
                  is_empty_flag, entry_count, error_code, output ready);
  modport mon    (input valid, ready, removed_value, removed_valid, head_value,
                  is_empty_flag, entry_count, error_code);
endinterface

>>> hdl/sorted_priority_queue.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Priority queue of CAPACITY entries held in descending priority order;
// newest first among equal priorities. Insert, remove head, report state.
// ----------------------------------------------------------------------------
//   Channel | Dir | Payload                                      | Word
//   req     | in  | func, item_value, item_priority              | one request
//   res     | out | removed_value, removed_valid, head_value,    | one result
//           |     | is_empty_flag, entry_count, error_code       |
//
// One request word a cycle unless the result stalls: every cell compares its
// priority with the request in parallel and shifts or holds in the same cycle.
// The result appears in the result register in the cycle after acceptance.
// A stalled result holds; a new request is taken in the cycle it drains.
// Reset empties the queue at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module sorted_priority_queue #(
  parameter int CAPACITY       = 16,
  parameter int DATA_WIDTH     = 32,
  parameter int PRIORITY_WIDTH = 16
) (
  input logic   clk,
  input logic   rst,
  spq_req_if.sink   req,
  spq_res_if.source res
);

  localparam int CW = $clog2(CAPACITY + 1);

  spq_pkg::cmd_t  cmd;
  spq_pkg::stat_t stat;

  spq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_func  (req.func),
    .req_ready (req.ready),
    .res_valid (res.valid),
    .res_ready (res.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  spq_dpath #(
    .CAPACITY (CAPACITY),
    .DW       (DATA_WIDTH),
    .PW       (PRIORITY_WIDTH),
    .CW       (CW)
  ) u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .in_value      (req.item_value),
    .in_priority   (req.item_priority),
    .removed_value (res.removed_value),
    .removed_valid (res.removed_valid),
    .head_value    (res.head_value),
    .is_empty_flag (res.is_empty_flag),
    .entry_count   (res.entry_count),
    .error_code    (res.error_code)
  );

endmodule

>>> hdl/spq_ctrl.sv
// ----------------------------------------------------------------------------
// spq_ctrl
// Handshake controller: accepts a request word when the result register is
// free or draining, decodes the operation against the fill state and issues
// one command to the datapath.
// ----------------------------------------------------------------------------
module spq_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  input  logic           req_func,
  output logic           req_ready,
  output logic           res_valid,
  input  logic           res_ready,
  input  spq_pkg::stat_t stat,
  output spq_pkg::cmd_t  cmd
);

  typedef enum logic {
    ST_IDLE,
    ST_HOLD
  } state_t;

  state_t state;
  logic   accept;

  // the result register parts the two sides: take a word while one drains
  assign req_ready = (state == ST_IDLE) || res_ready;
  assign accept    = req_valid && req_ready;

  always_comb begin
    cmd        = '0;
    cmd.load   = accept;
    cmd.insert = accept && (req_func == spq_pkg::FUNC_INSERT) && !stat.full;
    cmd.remove = accept && (req_func == spq_pkg::FUNC_REMOVE) && !stat.empty;
    if ((req_func == spq_pkg::FUNC_INSERT) && stat.full) begin
      cmd.err = spq_pkg::ERR_FULL;
    end else if ((req_func == spq_pkg::FUNC_REMOVE) && stat.empty) begin
      cmd.err = spq_pkg::ERR_EMPTY;
    end else begin
      cmd.err = spq_pkg::ERR_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      res_valid <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            state     <= ST_HOLD;
            res_valid <= 1'b1;
          end
        end
        ST_HOLD: begin
          if (res_ready && !accept) begin
            state     <= ST_IDLE;
            res_valid <= 1'b0;
          end
        end
        default: begin
          state     <= ST_IDLE;
          res_valid <= 1'b0;
        end
      endcase
    end
  end

endmodule

>>> hdl/spq_dpath.sv
// ----------------------------------------------------------------------------
// spq_dpath
// Shift-register queue: a row of cells kept in descending priority order,
// compared in parallel with the request priority, plus the result register.
// ----------------------------------------------------------------------------
module spq_dpath #(
  parameter int CAPACITY = 16,
  parameter int DW       = 32,
  parameter int PW       = 16,
  parameter int CW       = 5
) (
  input  logic           clk,
  input  logic           rst,
  input  spq_pkg::cmd_t  cmd,
  output spq_pkg::stat_t stat,
  input  logic [DW-1:0]  in_value,
  input  logic [PW-1:0]  in_priority,
  output logic [DW-1:0]  removed_value,
  output logic           removed_valid,
  output logic [DW-1:0]  head_value,
  output logic           is_empty_flag,
  output logic [CW-1:0]  entry_count,
  output logic [1:0]     error_code
);

  logic [DW-1:0] vals [CAPACITY];
  logic [PW-1:0] pris [CAPACITY];
  logic [DW-1:0] vals_next [CAPACITY];
  logic [PW-1:0] pris_next [CAPACITY];
  logic [CW-1:0] cnt;
  logic [CW-1:0] cnt_next;
  logic [CAPACITY-1:0] keep;
  logic [DW-1:0] head_next;

  assign stat.full  = (cnt == CW'(CAPACITY));
  assign stat.empty = (cnt == '0);

  // a held cell of strictly higher priority stays put; these form a prefix
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      keep[i] = (CW'(i) < cnt) && (pris[i] > in_priority);
    end
  end

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      vals_next[i] = vals[i];
      pris_next[i] = pris[i];
      if (cmd.insert) begin
        if (keep[i]) begin
          vals_next[i] = vals[i];
          pris_next[i] = pris[i];
        end else if (i == 0) begin
          vals_next[i] = in_value;
          pris_next[i] = in_priority;
        end else if (keep[i-1]) begin
          vals_next[i] = in_value;
          pris_next[i] = in_priority;
        end else begin
          vals_next[i] = vals[i-1];
          pris_next[i] = pris[i-1];
        end
      end else if (cmd.remove && (i < CAPACITY - 1)) begin
        vals_next[i] = vals[i+1];
        pris_next[i] = pris[i+1];
      end
    end
  end

  always_comb begin
    cnt_next = cnt;
    if (cmd.insert) begin
      cnt_next = cnt + CW'(1);
    end else if (cmd.remove) begin
      cnt_next = cnt - CW'(1);
    end
  end

  always_comb begin
    if (cmd.insert) begin
      head_next = keep[0] ? vals[0] : in_value;
    end else if (cmd.remove) begin
      head_next = (cnt > CW'(1)) ? vals[1] : '0;
    end else begin
      head_next = stat.empty ? '0 : vals[0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else begin
      cnt <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < CAPACITY; i++) begin
      vals[i] <= vals_next[i];
      pris[i] <= pris_next[i];
    end
  end

  // result word, written once per accepted request
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      removed_value <= cmd.remove ? vals[0] : '0;
      removed_valid <= cmd.remove;
      head_value    <= head_next;
      is_empty_flag <= (cnt_next == '0);
      entry_count   <= cnt_next;
      error_code    <= cmd.err;
    end
  end

endmodule

>>> hdl/spq_checker.sv
// ----------------------------------------------------------------------------
// spq_checker
// Port-level checks on the result channel of the priority queue.
// ----------------------------------------------------------------------------
module spq_checker #(
  parameter int CAPACITY = 16
) (
  input logic       clk,
  input logic       rst,
  spq_res_if.source res
);

  localparam int CW = $clog2(CAPACITY + 1);

  // a stalled result word stays offered
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    (res.valid && !res.ready) |=> res.valid)
    else $error("result word dropped while stalled");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> (res.entry_count <= CW'(CAPACITY)))
    else $error("entry count beyond capacity");

  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> (res.is_empty_flag == (res.entry_count == '0)))
    else $error("empty flag disagrees with count");

  a_full_error: assert property (@(posedge clk) disable iff (rst)
    (res.valid && (res.error_code == spq_pkg::ERR_FULL))
      |-> ((res.entry_count == CW'(CAPACITY)) && !res.removed_valid))
    else $error("full error while queue not full");

  a_removed_ok: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.removed_valid) |-> (res.error_code == spq_pkg::ERR_OK))
    else $error("removed word flagged with an error");

endmodule

bind sorted_priority_queue spq_checker #(
  .CAPACITY (CAPACITY)
) u_spq_checker (
  .clk (clk),
  .rst (rst),
  .res (res)
);
